// ===== hw/rtl/bm25s_pkg.sv =====
// shared types, constants and codes for the bm25 document scorer
// no dependencies
`default_nettype none
package bm25s_pkg;

	localparam int MAX_TERMS_DEF = 16;
	localparam int QDEPTH        = 2;
	// serial divider widths: numerator and divisor bits
	localparam int DIV_NW        = 56;
	localparam int DIV_DW        = 48;
	localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;
	localparam logic [40:0] RATIO_CAP   = 41'h100_0000_0000;
	localparam logic [16:0] B_ONE       = 17'h1_0000;

	typedef enum logic [2:0] {
		REG_K    = 3'd0,
		REG_B    = 3'd1,
		REG_N    = 3'd2,
		REG_AVG  = 3'd3,
		REG_CONJ = 3'd4,
		REG_UNIQ = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_NULL,
		KIND_TERM,
		KIND_LAST
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RATIO_W,
		ST_BR_LO,
		ST_BR_HI,
		ST_KN_LO,
		ST_KN_HI,
		ST_TFW,
		ST_TFW_W,
		ST_LOG_N,
		ST_LOG_S,
		ST_IDF,
		ST_TERM,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [15:0] k;
		logic [16:0] b;
		logic [31:0] num_docs;
		logic [31:0] avg;
		logic        conj;
		logic [4:0]  uniq;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [33:0] a;
		logic [32:0] d;
		logic [52:0] num;
		logic [15:0] tf;
		logic [23:0] len;
		logic [31:0] id;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bm25s_front.sv =====
// front end: classifies each input word and precomputes idf operands and tfw numerator
// depends on bm25s_pkg
`default_nettype none
module bm25s_front (
	input  wire logic            present,
	input  wire logic            last,
	input  wire logic [31:0]     df,
	input  wire logic [15:0]     tf,
	input  wire logic [23:0]     len,
	input  wire logic [31:0]     id,
	input  wire bm25s_pkg::cfg_t cfg,
	output bm25s_pkg::item_t     item
);
	import bm25s_pkg::*;

	logic [31:0] rest;
	logic [32:0] tfk;

	always_comb begin
		rest = (cfg.num_docs > df) ? (cfg.num_docs - df) : 32'd0;
		tfk  = 33'(tf) * 33'(17'(cfg.k) + 17'd4096);
		if (!present) begin
			item.kind = KIND_NULL;
		end else if (last) begin
			item.kind = KIND_LAST;
		end else begin
			item.kind = KIND_TERM;
		end
		item.a   = 34'({rest, 1'b0}) + 34'({df, 1'b0}) + 34'd2;
		item.d   = {df, 1'b1};
		item.num = {tfk, 20'b0};
		item.tf  = tf;
		item.len = len;
		item.id  = id;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bm25s_queue.sv =====
// short flop queue between front and back
// depends on bm25s_pkg
`default_nettype none
module bm25s_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire bm25s_pkg::item_t wr_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output bm25s_pkg::item_t      rd_item
);
	import bm25s_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	item_t         mem_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_item   = mem_q[rp_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= bump(wp_q);
			if (pop)  rp_q <= bump(rp_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_item;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bm25s_divider.sv =====
// restoring serial divider, one quotient bit per cycle
// depends on bm25s_pkg
`default_nettype none
module bm25s_divider (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bm25s_pkg::div_req_t  req,
	output bm25s_pkg::div_rsp_t       rsp
);
	import bm25s_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic              busy_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_DW:0]   rem_q;
	logic [DIV_DW-1:0] dsr_q;
	logic [DIV_NW-1:0] dvd_q;
	logic [DIV_DW:0]   sh;
	logic              qbit;

	always_comb begin
		sh   = {rem_q[DIV_DW-1:0], dvd_q[DIV_NW-1]};
		qbit = (sh >= {1'b0, dsr_q});
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			dvd_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? (sh - {1'b0, dsr_q}) : sh;
			dvd_q <= {dvd_q[DIV_NW-2:0], qbit};
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bm25s_back.sv =====
// back end: sequencer for length norm, tf weight, log2 idf, sum and output register
// depends on bm25s_pkg and bm25s_divider
`default_nettype none
module bm25s_back #(
	parameter int MAX_TERMS = bm25s_pkg::MAX_TERMS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bm25s_pkg::cfg_t  cfg,
	input  wire logic             q_valid,
	input  wire bm25s_pkg::item_t q_item,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [63:0]           m_tdata,
	output logic                  m_tuser
);
	import bm25s_pkg::*;

	localparam int TCW = $clog2(MAX_TERMS + 2);

	state_t state_q, state_n;
	div_req_t div_req;
	div_rsp_t div_rsp;

	item_t        cur_q;
	logic [40:0]  ratio_q, norm_q;
	logic [57:0]  prod_q;
	logic [45:0]  kn_q;
	logic [20:0]  tfw_q, idf_q;
	logic [33:0]  lx_q;
	logic [5:0]   le_q;
	logic [30:0]  lm_q;
	logic [15:0]  lf_q;
	logic [3:0]   li_q;
	logic         lsel_q;
	logic [21:0]  la_q, ld_q;
	logic [31:0]  sum_q;
	logic [TCW-1:0] tcnt_q;
	logic [31:0]  em_id_q, em_score_q;
	logic         em_ok_q;
	logic         out_v_q, out_flag_q;
	logic [63:0]  out_data_q;

	logic [57:0]  mul_full;
	logic [41:0]  norm_w;
	logic [47:0]  den;
	logic [61:0]  sq;
	logic [31:0]  sqs;
	logic [15:0]  lf_next;
	logic [52:0]  idf_p;
	logic [41:0]  term_p;
	logic [32:0]  sum_w;
	logic [31:0]  sum_sat;
	logic [TCW-1:0] tc_next;
	logic         conj_ok;
	logic         out_free;

	bm25s_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		mul_full = '0;
		unique case (state_q)
			ST_BR_HI: mul_full = prod_q + {34'(cfg.b * ratio_q[40:24]), 24'b0};
			ST_KN_HI: mul_full = prod_q + {34'(cfg.k * norm_q[40:24]), 24'b0};
			default:  mul_full = prod_q;
		endcase
		norm_w  = 42'(B_ONE - cfg.b) + mul_full[57:16];
		den     = 48'({cur_q.tf, 16'b0}) + 48'(kn_q);
		sq      = 62'(lm_q) * 62'(lm_q);
		sqs     = sq[61:30];
		lf_next = {lf_q[14:0], sqs[31]};
		idf_p   = 53'(la_q - ld_q) * 53'(LOG10_2_Q32);
		term_p  = 42'(idf_q) * 42'(tfw_q);
		sum_w   = 33'(sum_q) + 33'(term_p[41:16]);
		sum_sat = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
		tc_next = (tcnt_q < TCW'(MAX_TERMS + 1)) ? tcnt_q + 1'b1 : tcnt_q;
		conj_ok = !cfg.conj ||
			((32'(tc_next) == 32'(cfg.uniq)) && (cfg.uniq != 5'd0) &&
			 (32'(cfg.uniq) <= 32'(MAX_TERMS)));
		out_free = !out_v_q || m_tready;
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:
				if (q_valid) state_n = (q_item.kind == KIND_NULL) ? ST_EMIT : ST_RATIO_W;
			ST_RATIO_W: if (div_rsp.done) state_n = ST_BR_LO;
			ST_BR_LO:   state_n = ST_BR_HI;
			ST_BR_HI:   state_n = ST_KN_LO;
			ST_KN_LO:   state_n = ST_KN_HI;
			ST_KN_HI:   state_n = ST_TFW;
			ST_TFW:     state_n = (den == '0) ? ST_LOG_N : ST_TFW_W;
			ST_TFW_W:   if (div_rsp.done) state_n = ST_LOG_N;
			ST_LOG_N:   if (lx_q[33]) state_n = ST_LOG_S;
			ST_LOG_S:
				if (li_q == 4'd15) state_n = lsel_q ? ST_IDF : ST_LOG_N;
			ST_IDF:     state_n = ST_TERM;
			ST_TERM:
				state_n = (cur_q.kind == KIND_LAST && conj_ok) ? ST_EMIT : ST_IDLE;
			ST_EMIT:    if (out_free) state_n = ST_IDLE;
			default:    state_n = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop            = (state_q == ST_IDLE) && q_valid;
		div_req.start    = 1'b0;
		div_req.dividend = 56'({q_item.len, 24'b0});
		div_req.divisor  = 48'(cfg.avg);
		unique case (state_q)
			ST_IDLE: div_req.start = q_valid && (q_item.kind != KIND_NULL);
			ST_TFW: begin
				div_req.start    = (den != '0);
				div_req.dividend = 56'(cur_q.num);
				div_req.divisor  = den;
			end
			default: div_req.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			tcnt_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (q_pop && q_item.kind == KIND_NULL) begin
				sum_q  <= '0;
				tcnt_q <= '0;
			end
			if (state_q == ST_TERM) begin
				if (cur_q.kind == KIND_LAST) begin
					sum_q  <= '0;
					tcnt_q <= '0;
				end else begin
					sum_q  <= sum_sat;
					tcnt_q <= tc_next;
				end
			end
			if (state_q == ST_EMIT && out_free) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cur_q <= q_item;
				if (q_valid && q_item.kind == KIND_NULL) begin
					em_id_q    <= q_item.id;
					em_ok_q    <= 1'b0;
					em_score_q <= '0;
				end
			end
			ST_RATIO_W:
				if (div_rsp.done)
					ratio_q <= (div_rsp.quot > 56'(RATIO_CAP)) ? RATIO_CAP
						: div_rsp.quot[40:0];
			ST_BR_LO: prod_q <= 58'(41'(cfg.b) * 41'(ratio_q[23:0]));
			ST_BR_HI: norm_q <= norm_w[40:0];
			ST_KN_LO: prod_q <= 58'(40'(cfg.k) * 40'(norm_q[23:0]));
			ST_KN_HI: kn_q   <= mul_full[57:12];
			ST_TFW: begin
				tfw_q  <= '0;
				lx_q   <= cur_q.a;
				le_q   <= 6'd33;
				lsel_q <= 1'b0;
			end
			ST_TFW_W: if (div_rsp.done) tfw_q <= div_rsp.quot[20:0];
			ST_LOG_N: begin
				if (lx_q[33]) begin
					lm_q <= lx_q[33:3];
					lf_q <= '0;
					li_q <= '0;
				end else begin
					lx_q <= {lx_q[32:0], 1'b0};
					le_q <= le_q - 1'b1;
				end
			end
			ST_LOG_S: begin
				lm_q <= sqs[31] ? sqs[31:1] : sqs[30:0];
				lf_q <= lf_next;
				li_q <= li_q + 1'b1;
				if (li_q == 4'd15) begin
					if (lsel_q) begin
						ld_q <= {le_q, lf_next};
					end else begin
						la_q   <= {le_q, lf_next};
						lx_q   <= {1'b0, cur_q.d};
						le_q   <= 6'd33;
						lsel_q <= 1'b1;
					end
				end
			end
			ST_IDF: idf_q <= (la_q > ld_q) ? idf_p[52:32] : '0;
			ST_TERM: begin
				em_id_q    <= cur_q.id;
				em_ok_q    <= 1'b1;
				em_score_q <= sum_sat;
			end
			ST_EMIT:
				if (out_free) begin
					out_flag_q <= em_ok_q;
					out_data_q <= {em_score_q, em_id_q};
				end
			default: ;
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_flag_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bm25_document_scorer.sv =====
// top level of the bm25 document scorer: config registers, front, queue, back
// depends on bm25s_pkg, bm25s_front, bm25s_queue, bm25s_back
//
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata terms, tuser term present, tlast last of doc
// m_*       out  tvalid/tready      tdata id and score, tuser score valid
// cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// a term word passes through the back in this order: a 56-step serial division for
// the length ratio, the br_lo, br_hi, kn_lo and kn_hi multiply steps, a 56-step
// serial division for the tf weight (skipped when its divisor is zero), two log2
// passes of a load, up to 33 normalize shifts and 16 squarings, and the idf and term
// steps; a closing word also loads the output register and a null-document word
// only loads it; arst_n clears the config registers to their defaults, the sum, the
// term count and the output valid; the front keeps taking words into a two-word queue
// while the back works or waits on m_tready, until that queue is full
`default_nettype none
module bm25_document_scorer #(
	parameter int MAX_TERMS = bm25s_pkg::MAX_TERMS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [103:0] s_tdata,  // doc_freq, term_freq, doc_len, doc_id
	input  wire logic         s_tuser,  // term_present
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata,  // doc_out_id, score
	output logic              m_tuser,  // score_valid
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_addr,
	input  wire logic [31:0]  cfg_wdata
);
	import bm25s_pkg::*;

	// raw register copies
	logic [15:0] k_q;
	logic [16:0] b_q;
	logic [31:0] n_q, avg_q;
	logic        conj_q;
	logic [4:0]  uniq_q;

	cfg_t  cfg;
	item_t f_item, q_item;
	logic  q_full, q_valid, q_pop, push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= 16'd4915;
			b_q    <= 17'd49152;
			n_q    <= '0;
			avg_q  <= 32'd256;
			conj_q <= 1'b0;
			uniq_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_K:    k_q    <= cfg_wdata[15:0];
				REG_B:    b_q    <= cfg_wdata[16:0];
				REG_N:    n_q    <= cfg_wdata;
				REG_AVG:  avg_q  <= cfg_wdata;
				REG_CONJ: conj_q <= cfg_wdata[0];
				REG_UNIQ: uniq_q <= cfg_wdata[4:0];
				default:  ;
			endcase
		end
	end

	// b above one clamps to one, zero average length reads as one
	always_comb begin
		cfg.k        = k_q;
		cfg.b        = (b_q > B_ONE) ? B_ONE : b_q;
		cfg.num_docs = n_q;
		cfg.avg      = (avg_q == '0) ? 32'd1 : avg_q;
		cfg.conj     = conj_q;
		cfg.uniq     = uniq_q;
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	bm25s_front u_front (
		.present (s_tuser),
		.last    (s_tlast),
		.df      (s_tdata[31:0]),
		.tf      (s_tdata[47:32]),
		.len     (s_tdata[71:48]),
		.id      (s_tdata[103:72]),
		.cfg     (cfg),
		.item    (f_item)
	);

	bm25s_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rd_item   (q_item)
	);

	bm25s_back #(.MAX_TERMS(MAX_TERMS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/bm25s_checker.sv =====
// port-level checks for the bm25 document scorer, bound to the top level
// depends on bm25_document_scorer ports only
`default_nettype none
module bm25s_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [103:0] s_tdata,
	input wire logic         s_tuser,
	input wire logic         s_tlast,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [63:0]  m_tdata,
	input wire logic         m_tuser,
	input wire logic         cfg_we,
	input wire logic [2:0]   cfg_addr,
	input wire logic [31:0]  cfg_wdata
);

	// stalled result word keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// null row carries a zero score
	a_null: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[63:32] == 32'd0)
		else $error("null row with nonzero score");

	// result channel comes out of reset quiet
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

endmodule

bind bm25_document_scorer bm25s_checker u_chk (.*);
`default_nettype wire
